@@ rtl/ort_pkg.sv @@
package ort_pkg;

    // fixed geometry and angle constants
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int CORNER_COUNT       = 4;
    localparam int COORD_W            = 24;
    localparam int PROJ_W             = 51;
    localparam int DEG45              = 720;
    localparam int DEG90              = 1440;
    localparam int DEG180             = 2880;
    localparam int DEG270             = 4320;
    localparam int DEG360             = 5760;
    localparam int PIVOT_ONE          = 256;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_TRIG,
        ST_PIV,
        ST_PIVW,
        ST_CORN,
        ST_CORNW,
        ST_ROUND,
        ST_DEGEN,
        ST_PROJ,
        ST_PROJW,
        ST_PCHK,
        ST_FIN
    } state_t;

    // what the product in flight belongs to
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PIV,
        OP_CORN,
        OP_PROJ
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] step;
    } tag_t;

    // sine/cosine of t/16 degrees (t in 0..720), Taylor series at Q30,
    // rounded to tfb fraction bits; returns {cos, sin} in 32-bit halves
    function automatic logic [63:0] octant_sin_cos(input int unsigned t,
                                                   input int unsigned tfb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned k;
        longint unsigned s;
        longint unsigned c;
        longint unsigned half;
        x  = longint'(t) * PI_Q30 / DEG180;
        x2 = (x * x) >> 30;
        half = 64'd1 << (29 - tfb);
        k = ONE_Q30 - x2 / 72;
        k = ONE_Q30 - ((x2 * k) >> 30) / 42;
        k = ONE_Q30 - ((x2 * k) >> 30) / 20;
        k = ONE_Q30 - ((x2 * k) >> 30) / 6;
        s = (((x * k) >> 30) + half) >> (30 - tfb);
        k = ONE_Q30 - x2 / 90;
        k = ONE_Q30 - ((x2 * k) >> 30) / 56;
        k = ONE_Q30 - ((x2 * k) >> 30) / 30;
        k = ONE_Q30 - ((x2 * k) >> 30) / 12;
        c = ((ONE_Q30 - ((x2 * k) >> 30) / 2) + half) >> (30 - tfb);
        return {c[31:0], s[31:0]};
    endfunction

endpackage

@@ rtl/oriented_rect_overlap_test.sv @@
// Channel   Dir  Fields (tdata from bit 0 up)                          Sideband
// s_axis    in   pos_x, pos_y, rect_width, rect_height, pivot_frac_x,  tuser: is_second
//                pivot_frac_y, rot_angle
// m_axis    out  hit, degenerate                                       -
//
// A rectangle item is turned into corners and stored; a test item is projected onto
// 8 axes, stopping early when an axis separates, and skips projection when an edge
// is degenerate. A new item is taken only once the last is through. The single shared
// multiplier forms every pivot, corner and projection product; trig is a table.
// Reset (rst_n low, async) clears the sequencer and the stored rectangle.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only a new result stalls while the old one is unread.
module oriented_rect_overlap_test #(
    parameter int TRIG_FRAC_BITS = ort_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[19:0], pos_y[39:20], rect_width[55:40], rect_height[71:56],
    // pivot_frac_x[80:72], pivot_frac_y[89:81], rot_angle[102:90], zero pad
    input  logic [103:0] s_axis_tdata,
    // is_second[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], degenerate[1], zero pad
    output logic [7:0]   m_axis_tdata
);
    import ort_pkg::*;

    localparam int TFB   = TRIG_FRAC_BITS;
    localparam int TW    = TFB + 1;
    localparam int TS    = TFB + 2;
    localparam int SH    = 8 + TFB;
    localparam int MA_W  = 26;
    localparam int MB_W  = (TS > 25) ? TS : 25;
    localparam int PR_W  = MA_W + MB_W;
    localparam int ACC_W = (PR_W > 32 + TFB) ? PR_W : 32 + TFB;

    typedef logic [2*TW-1:0] rom_t [0:DEG45];

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] e;
        for (int t = 0; t <= DEG45; t++)
        begin
            e    = octant_sin_cos(t, TFB);
            r[t] = {e[32 +: TW], e[0 +: TW]};
        end
        return r;
    endfunction

    localparam rom_t TRIG_ROM = build_rom();

    state_t state_reg, state_next;
    logic [3:0] step_reg;
    logic [2:0] axis_reg;

    // item fields
    logic signed [19:0] pos_x_reg, pos_y_reg;
    logic [15:0]        w_reg, h_reg;
    logic [8:0]         pfx_reg, pfy_reg;
    logic               second_reg;
    logic [9:0]         idx_reg;
    logic               swap_reg;
    logic [1:0]         quad_reg;

    logic [2*TW-1:0]    rom_reg;
    logic signed [TS-1:0] sn_reg, cs_reg;

    // shared multiplier
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PR_W-1:0] prod_reg;
    tag_t                   tag_issue, tag_reg;

    logic signed [25:0]      pw_reg, ph_reg;
    logic signed [ACC_W-1:0] e0x_reg, e0y_reg;
    logic signed [PR_W-1:0]  u_reg, v_reg, p_reg, q_reg;

    logic signed [COORD_W-1:0] cur_x_reg [0:CORNER_COUNT-1];
    logic signed [COORD_W-1:0] cur_y_reg [0:CORNER_COUNT-1];
    logic signed [COORD_W-1:0] fst_x_reg [0:CORNER_COUNT-1];
    logic signed [COORD_W-1:0] fst_y_reg [0:CORNER_COUNT-1];
    logic                      fst_deg_reg;

    logic signed [PROJ_W-1:0] d_reg, lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic                     res_hit_reg, res_deg_reg;
    logic                     out_valid_reg, out_hit_reg, out_deg_reg;

    // accept-time angle reduction
    logic [12:0] ang_w;
    logic [12:0] ang_r;
    logic [1:0]  ang_q;
    logic [8:0]  pf_x_sat, pf_y_sat;

    always_comb
    begin
        ang_w = (s_axis_tdata[102:90] >= 13'(DEG360)) ?
                s_axis_tdata[102:90] - 13'(DEG360) : s_axis_tdata[102:90];
        priority if (ang_w < 13'(DEG90))
        begin
            ang_q = 2'd0;
            ang_r = ang_w;
        end
        else if (ang_w < 13'(DEG180))
        begin
            ang_q = 2'd1;
            ang_r = ang_w - 13'(DEG90);
        end
        else if (ang_w < 13'(DEG270))
        begin
            ang_q = 2'd2;
            ang_r = ang_w - 13'(DEG180);
        end
        else
        begin
            ang_q = 2'd3;
            ang_r = ang_w - 13'(DEG270);
        end
        pf_x_sat = (s_axis_tdata[80:72] > 9'(PIVOT_ONE)) ? 9'(PIVOT_ONE) : s_axis_tdata[80:72];
        pf_y_sat = (s_axis_tdata[89:81] > 9'(PIVOT_ONE)) ? 9'(PIVOT_ONE) : s_axis_tdata[89:81];
    end

    // quadrant signs on the octant values
    logic [TW-1:0]        rom_s, rom_c;
    logic signed [TS-1:0] sq, cq, sn_next, cs_next;

    always_comb
    begin
        rom_s = rom_reg[TW-1:0];
        rom_c = rom_reg[2*TW-1:TW];
        sq = swap_reg ? $signed({1'b0, rom_c}) : $signed({1'b0, rom_s});
        cq = swap_reg ? $signed({1'b0, rom_s}) : $signed({1'b0, rom_c});
        unique case (quad_reg)
            2'd0:    begin sn_next = sq;  cs_next = cq;  end
            2'd1:    begin sn_next = cq;  cs_next = -sq; end
            2'd2:    begin sn_next = -sq; cs_next = -cq; end
            default: begin sn_next = -cq; cs_next = sq;  end
        endcase
    end

    // edge vector of the current axis and corner picked for projection
    logic [1:0]                ei, ej, ci;
    logic signed [COORD_W:0]   vx, vy;
    logic signed [COORD_W-1:0] pxi, pxj, pyi, pyj, coord;

    always_comb
    begin
        ei  = axis_reg[1:0];
        ej  = axis_reg[1:0] + 2'd1;
        pxi = axis_reg[2] ? cur_x_reg[ei] : fst_x_reg[ei];
        pxj = axis_reg[2] ? cur_x_reg[ej] : fst_x_reg[ej];
        pyi = axis_reg[2] ? cur_y_reg[ei] : fst_y_reg[ei];
        pyj = axis_reg[2] ? cur_y_reg[ej] : fst_y_reg[ej];
        vx  = (COORD_W+1)'(pxi) - (COORD_W+1)'(pxj);
        vy  = (COORD_W+1)'(pyi) - (COORD_W+1)'(pyj);
        ci  = step_reg[2:1];
        if (step_reg[3])
            coord = step_reg[0] ? cur_y_reg[ci] : cur_x_reg[ci];
        else
            coord = step_reg[0] ? fst_y_reg[ci] : fst_x_reg[ci];
    end

    // corner assembly and rounding for the corner in step_reg
    logic signed [ACC_W-1:0]   ex, ey, rx, ry;
    logic                      use_w, use_h;

    always_comb
    begin
        use_w = (step_reg[1:0] == 2'd1) || (step_reg[1:0] == 2'd2);
        use_h = step_reg[1];
        ex = e0x_reg;
        ey = e0y_reg;
        if (use_w)
        begin
            ex = ex + (ACC_W'(u_reg) <<< 8);
            ey = ey + (ACC_W'(v_reg) <<< 8);
        end
        if (use_h)
        begin
            ex = ex - (ACC_W'(p_reg) <<< 8);
            ey = ey + (ACC_W'(q_reg) <<< 8);
        end
        rx = (ex + (ACC_W'(1) <<< (SH - 1))) >>> SH;
        ry = (ey + (ACC_W'(1) <<< (SH - 1))) >>> SH;
    end

    logic cur_degen;

    always_comb
    begin
        cur_degen = 1'b0;
        for (int i = 0; i < CORNER_COUNT; i++)
        begin
            if (cur_x_reg[i] == cur_x_reg[(i + 1) % CORNER_COUNT] &&
                cur_y_reg[i] == cur_y_reg[(i + 1) % CORNER_COUNT])
                cur_degen = 1'b1;
        end
    end

    logic signed [PROJ_W-1:0] d_sum;
    logic                     axis_ok;

    assign d_sum   = d_reg + PROJ_W'(prod_reg);
    assign axis_ok = (hi1_reg > lo2_reg) && (hi2_reg > lo1_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_TRIG;
            ST_TRIG:  state_next = ST_PIV;
            ST_PIV:   if (step_reg == 4'd1) state_next = ST_PIVW;
            ST_PIVW:  state_next = ST_CORN;
            ST_CORN:  if (step_reg == 4'd7) state_next = ST_CORNW;
            ST_CORNW: state_next = ST_ROUND;
            ST_ROUND: if (step_reg == 4'(CORNER_COUNT - 1)) state_next = ST_DEGEN;
            ST_DEGEN:
            begin
                priority if (!second_reg)
                    state_next = ST_IDLE;
                else if (fst_deg_reg || cur_degen)
                    state_next = ST_FIN;
                else
                    state_next = ST_PROJ;
            end
            ST_PROJ:  if (step_reg == 4'd15) state_next = ST_PROJW;
            ST_PROJW: state_next = ST_PCHK;
            ST_PCHK:  state_next = (!axis_ok || axis_reg == 3'd7) ? ST_FIN : ST_PROJ;
            ST_FIN:   if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb
    begin
        s_axis_tready  = (state_reg == ST_IDLE);
        mul_a          = '0;
        mul_b          = '0;
        tag_issue.op   = OP_NONE;
        tag_issue.step = step_reg;
        unique case (state_reg)
            ST_PIV:
            begin
                tag_issue.op = OP_PIV;
                mul_a = step_reg[0] ? MA_W'($signed({1'b0, h_reg}))
                                    : MA_W'($signed({1'b0, w_reg}));
                mul_b = step_reg[0] ? MB_W'($signed({1'b0, pfy_reg}))
                                    : MB_W'($signed({1'b0, pfx_reg}));
            end
            ST_CORN:
            begin
                tag_issue.op = OP_CORN;
                unique case (step_reg[2:0])
                    3'd0:    begin mul_a = pw_reg; mul_b = MB_W'(cs_reg); end
                    3'd1:    begin mul_a = ph_reg; mul_b = MB_W'(sn_reg); end
                    3'd2:    begin mul_a = pw_reg; mul_b = MB_W'(sn_reg); end
                    3'd3:    begin mul_a = ph_reg; mul_b = MB_W'(cs_reg); end
                    3'd4:    begin mul_a = MA_W'($signed({1'b0, w_reg})); mul_b = MB_W'(cs_reg); end
                    3'd5:    begin mul_a = MA_W'($signed({1'b0, w_reg})); mul_b = MB_W'(sn_reg); end
                    3'd6:    begin mul_a = MA_W'($signed({1'b0, h_reg})); mul_b = MB_W'(sn_reg); end
                    default: begin mul_a = MA_W'($signed({1'b0, h_reg})); mul_b = MB_W'(cs_reg); end
                endcase
            end
            ST_PROJ:
            begin
                tag_issue.op = OP_PROJ;
                mul_a = MA_W'(coord);
                mul_b = step_reg[0] ? MB_W'(vy) : MB_W'(vx);
            end
            default:
            begin
                tag_issue.op = OP_NONE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            tag_reg       <= '{op: OP_NONE, step: '0};
            out_valid_reg <= 1'b0;
            fst_deg_reg   <= 1'b0;
            for (int i = 0; i < CORNER_COUNT; i++)
            begin
                fst_x_reg[i] <= '0;
                fst_y_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? 4'd0 : step_reg + 4'd1;
            tag_reg   <= tag_issue;
            if (state_reg == ST_DEGEN)
                axis_reg <= '0;
            else if (state_reg == ST_PCHK)
                axis_reg <= axis_reg + 3'd1;
            // store the first rectangle
            if (state_reg == ST_DEGEN && !second_reg)
            begin
                fst_deg_reg <= cur_degen;
                for (int i = 0; i < CORNER_COUNT; i++)
                begin
                    fst_x_reg[i] <= cur_x_reg[i];
                    fst_y_reg[i] <= cur_y_reg[i];
                end
            end
            // result register
            if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            pos_x_reg  <= $signed(s_axis_tdata[19:0]);
            pos_y_reg  <= $signed(s_axis_tdata[39:20]);
            w_reg      <= s_axis_tdata[55:40];
            h_reg      <= s_axis_tdata[71:56];
            pfx_reg    <= pf_x_sat;
            pfy_reg    <= pf_y_sat;
            second_reg <= s_axis_tuser[0];
            quad_reg   <= ang_q;
            swap_reg   <= (ang_r > 13'(DEG45));
            idx_reg    <= (ang_r > 13'(DEG45)) ? 10'(13'(DEG90) - ang_r) : ang_r[9:0];
        end
        if (state_reg == ST_LOOK)
            rom_reg <= TRIG_ROM[idx_reg];
        if (state_reg == ST_TRIG)
        begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end

        prod_reg <= mul_a * mul_b;

        // seed of the rotated top-left corner
        if (state_reg == ST_CORN && step_reg == 4'd0)
        begin
            e0x_reg <= (ACC_W'(pos_x_reg) <<< SH) + (ACC_W'(pw_reg) <<< TFB);
            e0y_reg <= (ACC_W'(pos_y_reg) <<< SH) + (ACC_W'(ph_reg) <<< TFB);
        end

        // accumulate the product in flight
        unique case (tag_reg.op)
            OP_PIV:
            begin
                if (tag_reg.step[0])
                    ph_reg <= prod_reg[25:0];
                else
                    pw_reg <= prod_reg[25:0];
            end
            OP_CORN:
            begin
                unique case (tag_reg.step[2:0])
                    3'd0:    e0x_reg <= e0x_reg - ACC_W'(prod_reg);
                    3'd1:    e0x_reg <= e0x_reg + ACC_W'(prod_reg);
                    3'd2:    e0y_reg <= e0y_reg - ACC_W'(prod_reg);
                    3'd3:    e0y_reg <= e0y_reg - ACC_W'(prod_reg);
                    3'd4:    u_reg   <= prod_reg;
                    3'd5:    v_reg   <= prod_reg;
                    3'd6:    p_reg   <= prod_reg;
                    default: q_reg   <= prod_reg;
                endcase
            end
            OP_PROJ:
            begin
                if (!tag_reg.step[0])
                    d_reg <= PROJ_W'(prod_reg);
                else if (!tag_reg.step[3])
                begin
                    if (tag_reg.step[2:1] == 2'd0 || d_sum < lo1_reg) lo1_reg <= d_sum;
                    if (tag_reg.step[2:1] == 2'd0 || d_sum > hi1_reg) hi1_reg <= d_sum;
                end
                else
                begin
                    if (tag_reg.step[2:1] == 2'd0 || d_sum < lo2_reg) lo2_reg <= d_sum;
                    if (tag_reg.step[2:1] == 2'd0 || d_sum > hi2_reg) hi2_reg <= d_sum;
                end
            end
            default:
            begin
            end
        endcase

        if (state_reg == ST_ROUND)
        begin
            cur_x_reg[step_reg[1:0]] <= rx[COORD_W-1:0];
            cur_y_reg[step_reg[1:0]] <= ry[COORD_W-1:0];
        end

        // verdict
        if (state_reg == ST_DEGEN)
        begin
            res_hit_reg <= 1'b0;
            res_deg_reg <= fst_deg_reg || cur_degen;
        end
        else if (state_reg == ST_PCHK)
            res_hit_reg <= axis_ok;

        if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
        begin
            out_hit_reg <= res_hit_reg;
            out_deg_reg <= res_deg_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_deg_reg, out_hit_reg};

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_LOOK))
        else $error("accepted item did not start the sequence");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the final state");

    a_degen_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("hit reported together with degenerate");

    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (step_reg < 4'(CORNER_COUNT)))
        else $error("corner step out of range");
`endif

endmodule
